>>> sv/wtc_pkg.sv
// Shared constants, types and helper functions for the waveform timebase calibrator.
`default_nettype none

package wtc_pkg;

    // Geometry of the digitizer.
    localparam int CELLS    = 1024;
    localparam int CHANNELS = 4;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int CH_W    = 2;
    localparam int CELL_W  = 10;
    localparam int WIDTH_W = 20;
    localparam int RANGE_W = 11;
    localparam int ADC_W   = 16;
    localparam int TIME_W  = 32;
    localparam int VOLT_W  = 18;
    localparam int SUM_W   = 30;
    localparam int ADDR_W  = $clog2(CELLS * CHANNELS);

    // Command queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Volt offset unit: round(mv * 65536 / 1000) by reciprocal multiply.
    localparam int              X_W         = 27;
    localparam int              Q_W         = 18;
    localparam int              PROD_W      = 2 * X_W;
    localparam int              RECIP_SHIFT = 36;
    localparam logic [X_W-1:0]  RECIP       = X_W'(68719476);
    localparam logic [X_W-1:0]  ROUND_BIAS  = X_W'(500);
    localparam logic [X_W-1:0]  DIVISOR     = X_W'(1000);
    localparam logic [VOLT_W-1:0] HALF_SCALE = VOLT_W'(32768);
    localparam int              VOLT_LAT    = 3;

    // Start event sequence: one table read per channel, then the offset update.
    localparam int START_LAST = (CHANNELS + 1 > VOLT_LAT) ? CHANNELS + 1 : VOLT_LAT;
    localparam int STEP_W     = $clog2(START_LAST + 1);

    // Command codes on the request channel.
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    // Classified operation carried through the queue.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_START,
        OP_SAMPLE
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic [CH_W-1:0]            channel;
        logic [CELL_W-1:0]          cell_idx;
        logic [WIDTH_W-1:0]         width;
        logic signed [RANGE_W-1:0]  range_mv;
        logic [ADC_W-1:0]           adc;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef enum logic {
        ST_RUN,
        ST_START
    } back_state_t;

    // Table address of a cell of a channel.
    function automatic logic [ADDR_W-1:0] table_addr(input logic [CH_W-1:0] ch,
                                                     input logic [CELL_W-1:0] cell_idx);
        return ADDR_W'(ch) * ADDR_W'(CELLS) + ADDR_W'(cell_idx);
    endfunction

    // True when the channel number names an existing channel.
    function automatic logic channel_ok(input logic [CH_W-1:0] ch);
        return (32'(ch) < 32'(CHANNELS));
    endfunction

endpackage

`default_nettype wire

>>> sv/wtc_req_if.sv
// Request channel interface: commands, cell widths and raw samples.
`default_nettype none

interface wtc_req_if;
    logic                                valid;
    logic                                ready;
    logic [wtc_pkg::CMD_W-1:0]           command;
    logic [wtc_pkg::CH_W-1:0]            channel;
    logic [wtc_pkg::CELL_W-1:0]          cell_req;
    logic [wtc_pkg::WIDTH_W-1:0]         width;
    logic signed [wtc_pkg::RANGE_W-1:0]  range_mv;
    logic [wtc_pkg::ADC_W-1:0]           adc_sample;

    modport source (output valid, command, channel, cell_req, width, range_mv, adc_sample,
                    input ready);
    modport sink (input valid, command, channel, cell_req, width, range_mv, adc_sample,
                  output ready);
endinterface

`default_nettype wire

>>> sv/wtc_rsp_if.sv
// Response channel interface: calibrated time and voltage of one sample.
`default_nettype none

interface wtc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [wtc_pkg::CH_W-1:0]           out_channel;
    logic [wtc_pkg::CELL_W-1:0]         out_position;
    logic signed [wtc_pkg::TIME_W-1:0]  time_value;
    logic signed [wtc_pkg::VOLT_W-1:0]  volts;

    modport source (output valid, out_channel, out_position, time_value, volts,
                    input ready);
    modport sink (input valid, out_channel, out_position, time_value, volts,
                  output ready);
endinterface

`default_nettype wire

>>> sv/waveform_timebase_calibrator_core.sv
// A sample's result passes through the command queue, the read stage and the output register.
// One load or sample per cycle leaves the queue outside a start event, a sample only while the
// read stage is free; loads use the prefix table's write port, samples its read port. A start
// event leaves the queue, then one table read per channel, then the bases and offsets settle.
// Reset clears queue, pipeline, sums, bases, offsets and trigger cell; the prefix
// table keeps no reset and is not swept, so the block takes items right after reset.
`default_nettype none

module waveform_timebase_calibrator_core (
    input  logic      clk,
    input  logic      rst_n,
    wtc_req_if.sink   req,
    wtc_rsp_if.source rsp
);

    wtc_pkg::queue_head_t head;
    logic                 pop;

    // Accept and classify requests into the command queue.
    wtc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    // Execute queued commands and deliver calibrated samples.
    wtc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

>>> sv/wtc_front.sv
// Front part: accepts requests, classifies them and queues the ones that do work.
`default_nettype none

module wtc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    wtc_req_if.sink              req,
    output wtc_pkg::queue_head_t head,
    input  logic                 pop
);

    wtc_pkg::item_t              q_reg [wtc_pkg::QDEPTH];
    logic [wtc_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [wtc_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [wtc_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [wtc_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [wtc_pkg::QPTR_W:0]    count_reg;
    logic [wtc_pkg::QPTR_W:0]    count_next;
    logic                        accept;
    logic                        keep;
    logic                        push;
    logic                        do_pop;
    wtc_pkg::item_t              item;

    // Room in the queue means a transfer can be taken.
    assign req.ready = (count_reg < (wtc_pkg::QPTR_W + 1)'(wtc_pkg::QDEPTH));
    assign accept    = req.valid && req.ready;

    // Classify the request; unknown commands and absent channels are dropped here.
    always_comb
    begin
        item.channel  = req.channel;
        item.cell_idx = req.cell_req;
        item.width    = req.width;
        item.range_mv = req.range_mv;
        item.adc      = req.adc_sample;
        case (req.command)
            wtc_pkg::CMD_LOAD:
            begin
                item.op = wtc_pkg::OP_LOAD;
                keep    = wtc_pkg::channel_ok(req.channel);
            end
            wtc_pkg::CMD_START:
            begin
                item.op = wtc_pkg::OP_START;
                keep    = 1'b1;
            end
            wtc_pkg::CMD_SAMPLE:
            begin
                item.op = wtc_pkg::OP_SAMPLE;
                keep    = wtc_pkg::channel_ok(req.channel);
            end
            default:
            begin
                item.op = wtc_pkg::OP_LOAD;
                keep    = 1'b0;
            end
        endcase
    end

    assign push   = accept && keep;
    assign do_pop = pop && (count_reg != '0);

    // Queue pointer and fill count arithmetic.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> sv/wtc_volt_unit.sv
// Volt offset unit: round(range_mv * 65536 / 1000) - 32768 over three pipeline stages.
`default_nettype none

module wtc_volt_unit (
    input  logic                               clk,
    input  logic                               load,
    input  logic signed [wtc_pkg::RANGE_W-1:0] mv,
    output logic [wtc_pkg::VOLT_W-1:0]         offset
);

    logic [wtc_pkg::RANGE_W-1:0] mv_reg;
    logic [wtc_pkg::RANGE_W-1:0] mag;
    logic [wtc_pkg::X_W-1:0]     x;
    logic                        sign_a_reg;
    logic [wtc_pkg::X_W-1:0]     x_a_reg;
    logic [wtc_pkg::PROD_W-1:0]  prod_a_reg;
    logic [wtc_pkg::Q_W-1:0]     q_est;
    logic                        sign_b_reg;
    logic [wtc_pkg::X_W-1:0]     x_b_reg;
    logic [wtc_pkg::Q_W-1:0]     q_b_reg;
    logic [wtc_pkg::X_W-1:0]     prod_b_reg;
    logic [wtc_pkg::X_W-1:0]     remainder;
    logic [wtc_pkg::VOLT_W-1:0]  q_fix;
    logic [wtc_pkg::VOLT_W-1:0]  q_signed;
    logic [wtc_pkg::VOLT_W-1:0]  offset_reg;

    // Magnitude of the range in 2^-16 mV, with the rounding bias added.
    assign mag = mv_reg[wtc_pkg::RANGE_W-1] ? (wtc_pkg::RANGE_W'(0) - mv_reg) : mv_reg;
    assign x   = {mag, 16'b0} + wtc_pkg::ROUND_BIAS;

    // The reciprocal estimate is exact or one short.
    assign q_est = prod_a_reg[wtc_pkg::RECIP_SHIFT +: wtc_pkg::Q_W];

    // Correct the quotient with one compare, then apply the sign and half scale.
    always_comb
    begin
        remainder = x_b_reg - prod_b_reg;
        q_fix     = wtc_pkg::VOLT_W'(q_b_reg);
        if (remainder >= wtc_pkg::DIVISOR)
        begin
            q_fix = wtc_pkg::VOLT_W'(q_b_reg) + 1'b1;
        end
        q_signed = sign_b_reg ? (wtc_pkg::VOLT_W'(0) - q_fix) : q_fix;
    end

    // Operand latch and pipeline stages.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mv_reg <= mv;
        end
        sign_a_reg <= mv_reg[wtc_pkg::RANGE_W-1];
        x_a_reg    <= x;
        prod_a_reg <= wtc_pkg::PROD_W'(x) * wtc_pkg::PROD_W'(wtc_pkg::RECIP);
        sign_b_reg <= sign_a_reg;
        x_b_reg    <= x_a_reg;
        q_b_reg    <= q_est;
        prod_b_reg <= wtc_pkg::X_W'(q_est) * wtc_pkg::DIVISOR;
        offset_reg <= q_signed - wtc_pkg::HALF_SCALE;
    end

    assign offset = offset_reg;

endmodule

`default_nettype wire

>>> sv/wtc_back.sv
// Back part: prefix table, start event sequencer and the sample calibration pipeline.
`default_nettype none

module wtc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wtc_pkg::queue_head_t head,
    output logic                 pop,
    wtc_rsp_if.source            rsp
);

    // Prefix table and its ports.
    logic [wtc_pkg::SUM_W-1:0]   mem [wtc_pkg::CELLS * wtc_pkg::CHANNELS];
    logic [wtc_pkg::SUM_W-1:0]   rd_data_reg;
    logic                        we;
    logic                        re;
    logic [wtc_pkg::ADDR_W-1:0]  waddr;
    logic [wtc_pkg::ADDR_W-1:0]  raddr;
    logic [wtc_pkg::SUM_W-1:0]   wdata;

    // Calibration state.
    logic [wtc_pkg::SUM_W-1:0]   total_reg [wtc_pkg::CHANNELS];
    logic [wtc_pkg::SUM_W-1:0]   base_reg  [wtc_pkg::CHANNELS];
    logic [wtc_pkg::TIME_W-1:0]  align_reg [wtc_pkg::CHANNELS];
    logic [wtc_pkg::TIME_W-1:0]  align_calc [wtc_pkg::CHANNELS];
    logic [wtc_pkg::SUM_W-1:0]   run_calc  [wtc_pkg::CHANNELS];
    logic [wtc_pkg::CELL_W-1:0]  tc_reg;
    logic [wtc_pkg::VOLT_W-1:0]  volt_off_reg;
    logic [wtc_pkg::VOLT_W-1:0]  volt_calc;

    // Sequencer.
    wtc_pkg::back_state_t        state_reg;
    wtc_pkg::back_state_t        state_next;
    logic [wtc_pkg::STEP_W-1:0]  step_reg;
    logic [wtc_pkg::STEP_W-1:0]  step_next;
    logic                        load_pop;
    logic                        start_pop;
    logic                        sample_pop;
    logic                        base_capture;
    logic                        align_update;
    logic [wtc_pkg::CH_W-1:0]    base_ch;

    // Head item decode.
    logic [wtc_pkg::CH_W-1:0]    h_ch;
    logic [wtc_pkg::SUM_W-1:0]   h_total;
    logic [wtc_pkg::SUM_W-1:0]   load_prev;
    logic [wtc_pkg::CELL_W:0]    idx_sum;
    logic                        idx_wrap;
    logic [wtc_pkg::CELL_W-1:0]  idx;

    // Read stage of the sample pipeline.
    logic                        s1_valid_reg;
    logic [wtc_pkg::CH_W-1:0]    s1_ch_reg;
    logic [wtc_pkg::CELL_W-1:0]  s1_pos_reg;
    logic [wtc_pkg::SUM_W-1:0]   s1_add_reg;
    logic [wtc_pkg::SUM_W-1:0]   s1_base_reg;
    logic [wtc_pkg::TIME_W-1:0]  s1_align_reg;
    logic [wtc_pkg::ADC_W-1:0]   s1_adc_reg;
    logic                        s1_free;
    logic                        advance;

    // Output register.
    logic                        out_valid_reg;
    logic [wtc_pkg::CH_W-1:0]    out_ch_reg;
    logic [wtc_pkg::CELL_W-1:0]  out_pos_reg;
    logic [wtc_pkg::TIME_W-1:0]  out_time_reg;
    logic [wtc_pkg::VOLT_W-1:0]  out_volts_reg;
    logic [wtc_pkg::SUM_W-1:0]   sum_calc;

    wtc_volt_unit u_volt (
        .clk    (clk),
        .load   (start_pop),
        .mv     (head.item.range_mv),
        .offset (volt_calc)
    );

    // Head item: running sum for loads, circular table index for samples.
    assign h_ch      = head.item.channel;
    assign h_total   = total_reg[h_ch];
    assign load_prev = (head.item.cell_idx == '0) ? '0 : h_total;
    assign idx_sum   = {1'b0, tc_reg} + {1'b0, head.item.cell_idx};
    assign idx_wrap  = (idx_sum >= (wtc_pkg::CELL_W + 1)'(wtc_pkg::CELLS));
    assign idx       = idx_wrap ? wtc_pkg::CELL_W'(idx_sum - (wtc_pkg::CELL_W + 1)'(wtc_pkg::CELLS))
                                : wtc_pkg::CELL_W'(idx_sum);

    // The output register takes a new result when empty or when its transfer completes.
    assign advance = !out_valid_reg || rsp.ready;
    assign s1_free = !s1_valid_reg || advance;

    // Sequencer next state, queue pop and table port control.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        load_pop   = 1'b0;
        start_pop  = 1'b0;
        sample_pop = 1'b0;
        pop        = 1'b0;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = wtc_pkg::table_addr(h_ch, head.item.cell_idx);
        wdata      = load_prev;
        raddr      = wtc_pkg::table_addr(h_ch, idx);
        case (state_reg)
            wtc_pkg::ST_RUN:
            begin
                if (head.valid)
                begin
                    case (head.item.op)
                        wtc_pkg::OP_LOAD:
                        begin
                            load_pop = 1'b1;
                            pop      = 1'b1;
                            we       = 1'b1;
                        end
                        wtc_pkg::OP_SAMPLE:
                        begin
                            if (s1_free)
                            begin
                                sample_pop = 1'b1;
                                pop        = 1'b1;
                                re         = 1'b1;
                            end
                        end
                        wtc_pkg::OP_START:
                        begin
                            // The read port is shared, so the read stage must be empty.
                            if (!s1_valid_reg)
                            begin
                                start_pop  = 1'b1;
                                pop        = 1'b1;
                                state_next = wtc_pkg::ST_START;
                                step_next  = '0;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            wtc_pkg::ST_START:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg < wtc_pkg::STEP_W'(wtc_pkg::CHANNELS))
                begin
                    re    = 1'b1;
                    raddr = wtc_pkg::table_addr(wtc_pkg::CH_W'(step_reg), tc_reg);
                end
                if (step_reg == wtc_pkg::STEP_W'(wtc_pkg::START_LAST))
                begin
                    state_next = wtc_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = wtc_pkg::ST_RUN;
            end
        endcase
    end

    // Start event: each base read lands in the read data register and is captured in the step after it is issued.
    assign base_capture = (state_reg == wtc_pkg::ST_START) && (step_reg != '0)
                          && (step_reg <= wtc_pkg::STEP_W'(wtc_pkg::CHANNELS));
    assign base_ch      = wtc_pkg::CH_W'(step_reg - 1'b1);
    assign align_update = (state_reg == wtc_pkg::ST_START)
                          && (step_reg == wtc_pkg::STEP_W'(wtc_pkg::START_LAST));

    // Alignment of each channel's cell 0 to channel 0's.
    always_comb
    begin
        for (int ch = 0; ch < wtc_pkg::CHANNELS; ch++)
        begin
            run_calc[ch] = (tc_reg == '0) ? '0 : total_reg[ch] - base_reg[ch];
        end
        for (int ch = 0; ch < wtc_pkg::CHANNELS; ch++)
        begin
            align_calc[ch] = (ch == 0) ? '0
                           : wtc_pkg::TIME_W'(run_calc[0]) - wtc_pkg::TIME_W'(run_calc[ch]);
        end
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wtc_pkg::ST_RUN;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Calibration state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < wtc_pkg::CHANNELS; ch++)
            begin
                total_reg[ch] <= '0;
                base_reg[ch]  <= '0;
                align_reg[ch] <= '0;
            end
            tc_reg       <= '0;
            volt_off_reg <= '0;
        end
        else
        begin
            if (load_pop)
            begin
                total_reg[h_ch] <= load_prev + wtc_pkg::SUM_W'(head.item.width);
            end
            if (start_pop)
            begin
                tc_reg <= head.item.cell_idx;
            end
            if (base_capture)
            begin
                base_reg[base_ch] <= rd_data_reg;
            end
            if (align_update)
            begin
                for (int ch = 0; ch < wtc_pkg::CHANNELS; ch++)
                begin
                    align_reg[ch] <= align_calc[ch];
                end
                volt_off_reg <= volt_calc;
            end
        end
    end

    // Prefix table with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Read stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Read stage payload: per-channel terms are taken with the sample.
    always_ff @(posedge clk)
    begin
        if (sample_pop)
        begin
            s1_ch_reg    <= h_ch;
            s1_pos_reg   <= head.item.cell_idx;
            s1_add_reg   <= idx_wrap ? h_total : '0;
            s1_base_reg  <= base_reg[h_ch];
            s1_align_reg <= align_reg[h_ch];
            s1_adc_reg   <= head.item.adc;
        end
    end

    // Circular width sum from the trigger cell.
    assign sum_calc = rd_data_reg + s1_add_reg - s1_base_reg;

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_ch_reg    <= s1_ch_reg;
            out_pos_reg   <= s1_pos_reg;
            out_time_reg  <= wtc_pkg::TIME_W'(sum_calc) + s1_align_reg;
            out_volts_reg <= wtc_pkg::VOLT_W'(s1_adc_reg) + volt_off_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_channel  = out_ch_reg;
    assign rsp.out_position = out_pos_reg;
    assign rsp.time_value   = out_time_reg;
    assign rsp.volts        = out_volts_reg;

endmodule

`default_nettype wire
